### hw/rtl/motion_vector_ema_speed_angle_core_macros.svh
// Assertion macros shared by the RTL files
`ifndef MOTION_VECTOR_EMA_SPEED_ANGLE_CORE_MACROS_SVH
`define MOTION_VECTOR_EMA_SPEED_ANGLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MVESA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define MVESA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed during reset");
`else
`define MVESA_ASSERT(lbl, prop)
`define MVESA_ASSERT_RST(lbl, prop)
`endif
`endif

### hw/rtl/mvesa_pkg.sv
// Package: constants and arctangent table for the motion vector core
`timescale 1ns / 1ps
package mvesa_pkg;
  localparam int CORDIC_ITERS   = 16;
  localparam int ATAN_LEN       = 24;
  localparam int NITER          = (CORDIC_ITERS < ATAN_LEN) ? CORDIC_ITERS : ATAN_LEN;
  localparam int DIV_W          = 52;
  localparam int DIV_CW         = $clog2(DIV_W + 1);
  localparam int CFG_W          = 22;
  localparam int CFG_AW         = 2;

  localparam logic [CFG_AW-1:0] REG_FORCE_FPS = 2'd0;
  localparam logic [CFG_AW-1:0] REG_EMA_TAU   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_PX_PER_M  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_STEER     = 2'd3;

  localparam logic [19:0] DT_DEFAULT_US = 20'd66667;
  localparam logic [19:0] DT_MIN_US     = 20'd8333;
  localparam logic [19:0] DT_MAX_US     = 20'd200000;
  localparam logic [19:0] US_PER_S      = 20'd1000000;
  localparam logic [23:0] SPEED_MAX     = 24'hFFFFFF;
  localparam logic [20:0] MAG_MAX       = 21'd1048575;

  function automatic logic [29:0] atan_q16(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd294912000;
      5'd1:  v = 30'd174096719;
      5'd2:  v = 30'd91987925;
      5'd3:  v = 30'd46694507;
      5'd4:  v = 30'd23437865;
      5'd5:  v = 30'd11730358;
      5'd6:  v = 30'd5866610;
      5'd7:  v = 30'd2933484;
      5'd8:  v = 30'd1466764;
      5'd9:  v = 30'd733385;
      5'd10: v = 30'd366693;
      5'd11: v = 30'd183346;
      5'd12: v = 30'd91673;
      5'd13: v = 30'd45837;
      5'd14: v = 30'd22918;
      5'd15: v = 30'd11459;
      5'd16: v = 30'd5730;
      5'd17: v = 30'd2865;
      5'd18: v = 30'd1432;
      5'd19: v = 30'd716;
      5'd20: v = 30'd358;
      5'd21: v = 30'd179;
      5'd22: v = 30'd90;
      5'd23: v = 30'd45;
      default: v = 30'd0;
    endcase
    return v;
  endfunction
endpackage

### hw/rtl/mvesa_div.sv
// Shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`include "motion_vector_ema_speed_angle_core_macros.svh"
module mvesa_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mvesa_pkg::DIV_W-1:0] num,
  input  logic [mvesa_pkg::DIV_W-1:0] den,
  output logic                      done,
  output logic [mvesa_pkg::DIV_W-1:0] quo
);
  import mvesa_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_W-1:0]  num_r;
  logic [DIV_W-1:0]  den_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W:0]    rem_sh;
  logic [DIV_W:0]    rem_sub;
  logic              qbit;

  assign rem_sh  = {rem_r, num_r[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign qbit    = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      num_r <= {num_r[DIV_W-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quo  = num_r;

  `MVESA_ASSERT(a_start_idle, start |-> !busy_r)
  `MVESA_ASSERT(a_done_pulse, done_r |=> !done_r)
  `MVESA_ASSERT(a_busy_cnt, busy_r |-> (cnt_r != '0))
endmodule

### hw/rtl/motion_vector_ema_speed_angle_core.sv
// Top level: frame time, EMA, magnitude, speed, folded angle and steer
//
// One transaction in gives one transaction out. An item may also wait for
// out_tready on the previous result. A pass through the shared divider runs
// 52 quotient steps plus start and finish. There are up to four passes: frame
// time from a forced rate, the two EMA updates and the speed. On top of that
// come a bit-serial square root, 16 CORDIC rotations (skipped for a zero
// vector) and a few multiply steps, all run by one sequencer. The shortest
// item has a measured frame time, no EMA and a zero vector; the longest has a
// forced rate and a running EMA.
// in_tready is high only while the sequencer is idle.
`timescale 1ns / 1ps
`include "motion_vector_ema_speed_angle_core_macros.svh"
module motion_vector_ema_speed_angle_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mvesa_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [mvesa_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [63:0]                   in_tdata,   // mean_dx, mean_dy, frame_dt_us
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // filt_dx, filt_dy, magnitude, speed_mm_per_s, angle_cdeg, steer_cdeg
  output logic [127:0]                  out_tdata
);
  import mvesa_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DT, ST_DTW, ST_EMA, ST_MX, ST_DX, ST_DXW, ST_MY, ST_DY, ST_DYW,
    ST_SQX, ST_SQY, ST_SQS, ST_SQRT, ST_RND, ST_PD, ST_PN, ST_PS, ST_SPW,
    ST_CINIT, ST_CORD, ST_ANG, ST_STR, ST_STR2, ST_OUT
  } state_t;

  state_t             state_r;
  logic [7:0]         fps_r;
  logic [21:0]        tau_r;
  logic [19:0]        px_r;
  logic signed [15:0] ratio_r;
  logic               ema_valid_r;
  logic signed [19:0] ema_x_r, ema_y_r;
  logic signed [19:0] vx_r, vy_r;
  logic [19:0]        meas_r;
  logic [19:0]        dt_r;
  logic               neg_r;
  logic signed [63:0] prod_r;
  logic [39:0]        sq_n_r, sq_root_r, sq_bit_r;
  logic [4:0]         cnt_r;
  logic [19:0]        mag_r;
  logic [43:0]        den_r;
  logic [23:0]        speed_r;
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic signed [14:0] ang_r;
  logic signed [21:0] steer_r;
  logic               out_tvalid_r;
  logic [127:0]       out_tdata_r;
  logic               div_start_r;
  logic [DIV_W-1:0]   div_num_r, div_den_r;
  logic               div_done;
  logic [DIV_W-1:0]   div_quo;

  logic signed [31:0] mul_a, mul_b;
  logic signed [20:0] diff_x, diff_y;
  logic [22:0]        ema_d;
  logic [63:0]        prod_abs;
  logic signed [20:0] q_s;
  logic signed [20:0] ema_x_new, ema_y_new;
  logic [19:0]        dt_clamp;
  logic [19:0]        px_eff;
  logic [40:0]        sq_trial;
  logic [40:0]        sq_rnd;
  logic signed [31:0] cx_sh, cy_sh, atan_v;
  logic [31:0]        cz_abs;
  logic [32:0]        cz_rnd;
  logic signed [17:0] ang_full;
  logic [31:0]        st_abs;
  logic signed [24:0] st_full;
  logic               div_wait;

  assign diff_x    = {vx_r[19], vx_r} - {ema_x_r[19], ema_x_r};
  assign diff_y    = {vy_r[19], vy_r} - {ema_y_r[19], ema_y_r};
  assign ema_d     = {1'b0, tau_r} + {3'b0, dt_r};
  assign prod_abs  = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
  assign q_s       = neg_r ? -$signed(div_quo[20:0]) : $signed(div_quo[20:0]);
  assign ema_x_new = {ema_x_r[19], ema_x_r} + q_s;
  assign ema_y_new = {ema_y_r[19], ema_y_r} + q_s;
  assign dt_clamp  = (meas_r == 20'd0) ? DT_DEFAULT_US :
                     (meas_r < DT_MIN_US) ? DT_MIN_US :
                     (meas_r > DT_MAX_US) ? DT_MAX_US : meas_r;
  assign px_eff    = (px_r == 20'd0) ? 20'd1 : px_r;
  assign sq_trial  = {1'b0, sq_root_r} + {1'b0, sq_bit_r};
  assign sq_rnd    = (sq_n_r > sq_root_r) ? ({1'b0, sq_root_r} + 41'd1) : {1'b0, sq_root_r};
  assign cx_sh     = cx_r >>> cnt_r;
  assign cy_sh     = cy_r >>> cnt_r;
  assign atan_v    = $signed({2'b0, atan_q16(cnt_r)});
  assign cz_abs    = cz_r[31] ? 32'(-cz_r) : 32'(cz_r);
  assign cz_rnd    = {1'b0, cz_abs} + 33'd32768;
  assign ang_full  = cz_r[31] ? $signed({1'b0, cz_rnd[32:16]}) : -$signed({1'b0, cz_rnd[32:16]});
  assign st_abs    = prod_abs[31:0] + 32'd128;
  assign st_full   = prod_r[63] ? -$signed({1'b0, st_abs[31:8]}) : $signed({1'b0, st_abs[31:8]});
  assign div_wait  = (state_r == ST_DTW) || (state_r == ST_DXW) ||
                     (state_r == ST_DYW) || (state_r == ST_SPW);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MX:  begin mul_a = 32'(diff_x); mul_b = $signed({12'b0, dt_r}); end
      ST_MY:  begin mul_a = 32'(diff_y); mul_b = $signed({12'b0, dt_r}); end
      ST_SQX: begin mul_a = 32'(vx_r); mul_b = 32'(vx_r); end
      ST_SQY: begin mul_a = 32'(vy_r); mul_b = 32'(vy_r); end
      ST_PD:  begin mul_a = $signed({12'b0, px_eff}); mul_b = $signed({12'b0, dt_r}); end
      ST_PN:  begin mul_a = $signed({12'b0, mag_r}); mul_b = 32'sd1000000000; end
      ST_STR: begin mul_a = 32'(ang_r); mul_b = 32'(ratio_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  mvesa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fps_r        <= 8'd15;
      tau_r        <= 22'd250000;
      px_r         <= 20'd11472;
      ratio_r      <= 16'sd256;
      ema_valid_r  <= 1'b0;
      ema_x_r      <= '0;
      ema_y_r      <= '0;
      out_tvalid_r <= 1'b0;
      div_start_r  <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_addr)
          REG_FORCE_FPS: fps_r   <= cfg_wdata[7:0];
          REG_EMA_TAU:   tau_r   <= cfg_wdata[21:0];
          REG_PX_PER_M:  px_r    <= cfg_wdata[19:0];
          REG_STEER:     ratio_r <= $signed(cfg_wdata[15:0]);
          default: ;
        endcase
      end
      if (out_tvalid_r && out_tready && state_r != ST_OUT) out_tvalid_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_tvalid) begin
          vx_r    <= $signed(in_tdata[19:0]);
          vy_r    <= $signed(in_tdata[39:20]);
          meas_r  <= in_tdata[59:40];
          state_r <= ST_DT;
        end
        ST_DT: if (fps_r != 8'd0) begin
          div_num_r   <= DIV_W'(US_PER_S) + DIV_W'(fps_r[7:1]);
          div_den_r   <= DIV_W'(fps_r);
          div_start_r <= 1'b1;
          state_r     <= ST_DTW;
        end else begin
          dt_r    <= dt_clamp;
          state_r <= ST_EMA;
        end
        ST_DTW: if (div_done) begin
          dt_r    <= div_quo[19:0];
          state_r <= ST_EMA;
        end
        ST_EMA: if (tau_r == 22'd0) begin
          state_r <= ST_SQX;
        end else if (!ema_valid_r) begin
          ema_valid_r <= 1'b1;
          ema_x_r     <= vx_r;
          ema_y_r     <= vy_r;
          state_r     <= ST_SQX;
        end else begin
          state_r <= ST_MX;
        end
        ST_MX: state_r <= ST_DX;
        ST_DX: begin
          neg_r       <= prod_r[63];
          div_num_r   <= prod_abs[DIV_W-1:0] + DIV_W'(ema_d[22:1]);
          div_den_r   <= DIV_W'(ema_d);
          div_start_r <= 1'b1;
          state_r     <= ST_DXW;
        end
        ST_DXW: if (div_done) begin
          ema_x_r <= ema_x_new[19:0];
          vx_r    <= ema_x_new[19:0];
          state_r <= ST_MY;
        end
        ST_MY: state_r <= ST_DY;
        ST_DY: begin
          neg_r       <= prod_r[63];
          div_num_r   <= prod_abs[DIV_W-1:0] + DIV_W'(ema_d[22:1]);
          div_den_r   <= DIV_W'(ema_d);
          div_start_r <= 1'b1;
          state_r     <= ST_DYW;
        end
        ST_DYW: if (div_done) begin
          ema_y_r <= ema_y_new[19:0];
          vy_r    <= ema_y_new[19:0];
          state_r <= ST_SQX;
        end
        ST_SQX: state_r <= ST_SQY;
        ST_SQY: begin
          sq_n_r  <= prod_r[39:0];
          state_r <= ST_SQS;
        end
        ST_SQS: begin
          sq_n_r    <= sq_n_r + prod_r[39:0];
          sq_root_r <= '0;
          sq_bit_r  <= 40'h1 << 38;
          cnt_r     <= 5'd20;
          state_r   <= ST_SQRT;
        end
        ST_SQRT: begin
          if ({1'b0, sq_n_r} >= sq_trial) begin
            sq_n_r    <= sq_n_r - sq_trial[39:0];
            sq_root_r <= (sq_root_r >> 1) + sq_bit_r;
          end else begin
            sq_root_r <= sq_root_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
          cnt_r    <= cnt_r - 5'd1;
          if (cnt_r == 5'd1) state_r <= ST_RND;
        end
        ST_RND: begin
          mag_r   <= (sq_rnd > 41'(MAG_MAX)) ? MAG_MAX[19:0] : sq_rnd[19:0];
          state_r <= ST_PD;
        end
        ST_PD: state_r <= ST_PN;
        ST_PN: begin
          den_r   <= {prod_r[39:0], 4'b0};
          state_r <= ST_PS;
        end
        ST_PS: begin
          div_num_r   <= DIV_W'(prod_r[49:0]) + DIV_W'(den_r[43:1]);
          div_den_r   <= DIV_W'(den_r);
          div_start_r <= 1'b1;
          state_r     <= ST_SPW;
        end
        ST_SPW: if (div_done) begin
          speed_r <= (div_quo > DIV_W'(SPEED_MAX)) ? SPEED_MAX : div_quo[23:0];
          state_r <= ST_CINIT;
        end
        ST_CINIT: if (vx_r == 20'sd0 && vy_r == 20'sd0) begin
          ang_r   <= '0;
          state_r <= ST_STR;
        end else begin
          cx_r    <= vx_r[19] ? -(32'(vx_r) <<< 8) : (32'(vx_r) <<< 8);
          cy_r    <= 32'(vy_r) <<< 8;
          cz_r    <= '0;
          cnt_r   <= '0;
          state_r <= ST_CORD;
        end
        ST_CORD: begin
          if (cy_r > 32'sd0) begin
            cx_r <= cx_r + cy_sh;
            cy_r <= cy_r - cx_sh;
            cz_r <= cz_r + atan_v;
          end else begin
            cx_r <= cx_r - cy_sh;
            cy_r <= cy_r + cx_sh;
            cz_r <= cz_r - atan_v;
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(NITER - 1)) state_r <= ST_ANG;
        end
        ST_ANG: begin
          if (ang_full > 18'sd9000) ang_r <= 15'sd9000;
          else if (ang_full < -18'sd9000) ang_r <= -15'sd9000;
          else ang_r <= ang_full[14:0];
          state_r <= ST_STR;
        end
        ST_STR: state_r <= ST_STR2;
        ST_STR2: begin
          if (st_full > 25'sd2097151) steer_r <= 22'sd2097151;
          else if (st_full < -25'sd2097152) steer_r <= $signed(22'h200000);
          else steer_r <= st_full[21:0];
          state_r <= ST_OUT;
        end
        ST_OUT: if (!out_tvalid_r || out_tready) begin
          out_tvalid_r <= 1'b1;
          out_tdata_r  <= {7'b0, steer_r, ang_r, speed_r, mag_r, vy_r, vx_r};
          state_r      <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `MVESA_ASSERT(a_acc_busy, (in_tvalid && in_tready) |=> !in_tready)
  `MVESA_ASSERT(a_div_wait, div_done |-> div_wait)
  `MVESA_ASSERT(a_ema_seed, $rose(ema_valid_r) |-> (tau_r != 22'd0))
  `MVESA_ASSERT_RST(a_rst_out, !rst_n |=> !out_tvalid)
endmodule

### tb/sv/motion_vector_ema_speed_angle_checker.sv
// Checker: watches config, input and result channels, predicts each result and compares
`timescale 1ns / 1ps
module motion_vector_ema_speed_angle_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [mvesa_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [mvesa_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [63:0]                  in_tdata,
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [127:0]                 out_tdata,
  output int                           n_fail,
  output int                           n_pending,
  output int                           n_checked
);
  import mvesa_pkg::*;

  typedef struct packed {
    logic [21:0] steer;
    logic [14:0] angle;
    logic [23:0] speed;
    logic [19:0] mag;
    logic [19:0] fy;
    logic [19:0] fx;
  } motion_t;

  localparam longint ATAN_CDEG_Q16 [24] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466764, 733385, 366693, 183346,
    91673, 45837, 22918, 11459, 5730, 2865,
    1432, 716, 358, 179, 90, 45
  };

  longint fps_r, tau_r, px_r, steer_r;
  bit     ema_seeded;
  longint ema_x, ema_y;
  motion_t expected_q[$];

  function automatic longint round_div(longint num, longint den);
    longint m;
    longint q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint sqrt_nearest(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (n > r) r++;
    return longint'(r);
  endfunction

  function automatic longint fold_angle(longint dx, longint dy);
    longint x, y, z, xs, ys;
    if (dx == 0 && dy == 0) return 0;
    x = ((dx < 0) ? -dx : dx) * 256;
    y = dy * 256;
    z = 0;
    for (int i = 0; i < NITER; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_CDEG_Q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_CDEG_Q16[i];
      end
    end
    z = -round_div(z, 65536);
    if (z > 9000) z = 9000;
    if (z < -9000) z = -9000;
    return z;
  endfunction

  function automatic motion_t predict_motion(logic [63:0] d);
    longint dx, dy, meas, dt, den, mag, spd, ang, st, px;
    motion_t r;
    dx = longint'($signed(d[19:0]));
    dy = longint'($signed(d[39:20]));
    meas = longint'(d[59:40]);
    if (fps_r > 0) dt = (1000000 + fps_r / 2) / fps_r;
    else if (meas == 0) dt = 66667;
    else begin
      dt = meas;
      if (dt < 8333) dt = 8333;
      if (dt > 200000) dt = 200000;
    end
    if (tau_r > 0) begin
      if (!ema_seeded) begin
        ema_seeded = 1'b1;
        ema_x = dx;
        ema_y = dy;
      end else begin
        den = tau_r + dt;
        ema_x = ema_x + round_div((dx - ema_x) * dt, den);
        ema_y = ema_y + round_div((dy - ema_y) * dt, den);
      end
      dx = ema_x;
      dy = ema_y;
    end
    mag = sqrt_nearest(longint'(dx * dx + dy * dy));
    if (mag > 1048575) mag = 1048575;
    px = (px_r != 0) ? px_r : 1;
    den = 16 * px * dt;
    spd = (mag * 1000000000 + den / 2) / den;
    if (spd > 16777215) spd = 16777215;
    ang = fold_angle(dx, dy);
    st = round_div(ang * steer_r, 256);
    if (st > 2097151) st = 2097151;
    if (st < -2097152) st = -2097152;
    r.fx = dx[19:0];
    r.fy = dy[19:0];
    r.mag = mag[19:0];
    r.speed = spd[23:0];
    r.angle = ang[14:0];
    r.steer = st[21:0];
    return r;
  endfunction

  task automatic check_field(string nm, longint e, longint a);
    if (e != a) begin
      n_fail++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, nm, e, a);
    end
  endtask

  always @(posedge clk) begin
    motion_t e;
    motion_t a;
    if (!rst_n) begin
      fps_r = 15;
      tau_r = 250000;
      px_r = 11472;
      steer_r = 256;
      ema_seeded = 1'b0;
      ema_x = 0;
      ema_y = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_FORCE_FPS: fps_r = longint'(cfg_wdata[7:0]);
          REG_EMA_TAU:   tau_r = longint'(cfg_wdata[21:0]);
          REG_PX_PER_M:  px_r = longint'(cfg_wdata[19:0]);
          REG_STEER:     steer_r = longint'($signed(cfg_wdata[15:0]));
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_q.insert(expected_q.size(), predict_motion(in_tdata));
      if (out_tvalid && out_tready) begin
        a = out_tdata[120:0];
        if (expected_q.size() == 0) begin
          n_fail++;
          $display("%0t ns: unexpected result, expected none, got %h", $time, out_tdata);
        end else begin
          e = expected_q.pop_front();
          n_checked++;
          check_field("filt_dx", $signed(e.fx), $signed(a.fx));
          check_field("filt_dy", $signed(e.fy), $signed(a.fy));
          check_field("magnitude", e.mag, a.mag);
          check_field("speed_mm_per_s", e.speed, a.speed);
          check_field("angle_cdeg", $signed(e.angle), $signed(a.angle));
          check_field("steer_cdeg", $signed(e.steer), $signed(a.steer));
          if (out_tdata[127:121] != 0) begin
            n_fail++;
            $display("%0t ns: pad bits, expected 0, got %h", $time, out_tdata[127:121]);
          end
        end
      end
    end
    n_pending = expected_q.size();
  end
endmodule

### tb/sv/tb_motion_vector_ema_speed_angle_core.sv
// Testbench top: clock, reset, config phases, stimulus, back-pressure and verdict
`timescale 1ns / 1ps
module tb_motion_vector_ema_speed_angle_core;
  import mvesa_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int DRAIN_CYCLES = 300;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [CFG_W-1:0]    cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [63:0]         in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [127:0]        out_tdata;
  int                  n_fail, n_pending, n_checked;
  int                  in_idle_pct, out_idle_pct;
  int                  hold_req;
  int                  n_sent, n_cfg;
  longint              cycles;

  motion_vector_ema_speed_angle_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  motion_vector_ema_speed_angle_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .n_fail(n_fail), .n_pending(n_pending), .n_checked(n_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("timeout after %0d cycles", cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a long hold on request
  initial begin
    int hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_tready = 1'b0;
      end else begin
        out_tready = ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  task automatic send_vec(logic [19:0] dx, logic [19:0] dy, logic [19:0] dt);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {4'b0, dt, dy, dx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    n_cfg++;
  endtask

  task automatic drain();
    while (n_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic configure(int fps, int tau, int px, int steer);
    drain();
    write_reg(REG_FORCE_FPS, CFG_W'(fps));
    write_reg(REG_EMA_TAU, CFG_W'(tau));
    write_reg(REG_PX_PER_M, CFG_W'(px));
    write_reg(REG_STEER, CFG_W'(steer));
  endtask

  task automatic random_vecs(int count);
    logic [19:0] dx, dy, dt;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: begin
          dx = 20'($urandom);
          dy = 20'($urandom);
        end
        1: begin
          dx = 20'(int'($urandom_range(4096)) - 2048);
          dy = 20'(int'($urandom_range(4096)) - 2048);
        end
        2: begin
          dx = $urandom_range(1) ? 20'h80000 : 20'h7FFFF;
          dy = 20'($urandom);
        end
        default: begin
          dx = $urandom_range(1) ? 20'd0 : 20'($urandom);
          dy = $urandom_range(1) ? 20'd0 : 20'($urandom_range(255));
        end
      endcase
      case ($urandom_range(4))
        0: dt = '0;
        1: dt = 20'($urandom_range(8333));
        2: dt = 20'($urandom_range(200000, 8333));
        default: dt = 20'($urandom);
      endcase
      send_vec(dx, dy, dt);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_idle_pct = 14;
    out_idle_pct = 45;
    hold_req = 0;
    n_sent = 0;
    n_cfg = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: seed the average, then extremes
    send_vec(20'h00000, 20'h00000, 20'd0);
    send_vec(20'h7FFFF, 20'h7FFFF, 20'd1);
    send_vec(20'h80000, 20'h80000, 20'hFFFFF);
    send_vec(20'h80000, 20'h7FFFF, 20'd8333);
    send_vec(20'h00000, 20'h00100, 20'd200000);
    configure(0, 0, 16, 32767);
    send_vec(20'h00000, 20'h00000, 20'd0);
    send_vec(20'h00000, 20'h7FFFF, 20'd1);
    send_vec(20'h00000, 20'h80000, 20'd8332);
    send_vec(20'h7FFFF, 20'h00000, 20'd8333);
    send_vec(20'h80000, 20'h00000, 20'd200000);
    send_vec(20'h80000, 20'h80000, 20'd200001);
    send_vec(20'h7FFFF, 20'h7FFFF, 20'hFFFFF);
    send_vec(20'h00100, 20'hFFF00, 20'd33333);
    send_vec(20'hFFF00, 20'h00100, 20'd0);
    send_vec(20'h00001, 20'hFFFFF, 20'd16667);
    configure(255, 1, 0, 16'h8000);
    send_vec(20'h7FFFF, 20'h80000, 20'd0);
    send_vec(20'h80000, 20'h7FFFF, 20'd0);
    send_vec(20'h00000, 20'h00000, 20'd0);
    send_vec(20'h00200, 20'hFFE00, 20'd0);

    // random phases across settings and idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(0, 250000, 11472, 256);
        1: configure(240, 4000000, 1048575, 32767);
        2: configure(0, 0, 16, 16'h8000);
        3: configure($urandom_range(240), $urandom_range(4000000),
                     $urandom_range(1048575, 16), $urandom);
        4: configure(0, $urandom_range(100000), $urandom_range(20000, 16), $urandom);
        default: configure($urandom_range(1) ? 0 : 30, 4000000, 11472, 16'hFF00);
      endcase
      if (ph == 2) begin
        in_idle_pct = 45;
        out_idle_pct = 14;
      end else if (ph == 4) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      if (ph == 1 || ph == 4) hold_req = 1500;
      random_vecs(105);
    end

    drain();
    $display("sent %0d motion vectors, checked %0d results, %0d register writes",
             n_sent, n_checked, n_cfg);
    $display("covered forced and measured frame time, EMA on/off, saturation, stalls");
    if (n_fail == 0 && n_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
